// ===== design/sli_pkg.sv =====
// Shared types and codes for the sorted list insert block.
// Used by sli_cell, sli_ctrl and sorted_list_insert; no dependencies.
package sli_pkg;

  localparam int unsigned DEPTH_DEF = 32;
  localparam int unsigned DATA_W    = 32;

  typedef logic signed [DATA_W-1:0] data_t;

  // Input operation codes
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_READ   = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  // Result kind codes
  typedef enum logic [2:0] {
    KIND_INSERTED = 3'd0,
    KIND_FULL     = 3'd1,
    KIND_ENTRY    = 3'd2,
    KIND_EMPTY    = 3'd3,
    KIND_CLEARED  = 3'd4
  } kind_t;

  // Per-cycle command broadcast to every cell of the chain
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_ROTATE = 2'd2
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    data_t    value;
  } cell_cmd_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } state_t;

endpackage

// ===== design/sorted_list_insert.sv =====
// Sorted list insert: ascending list of signed 32-bit values held in a
// chain of compare-and-shift cells (sli_cell) under sli_ctrl. Uses sli_pkg.
//
// Input channel (in_valid / in_stall): in_operation selects insert, read or
// clear; in_value is the value to insert. Result channel (out_valid /
// out_stall): out_kind, out_entry, out_last; out_last marks the final
// result of each input item.
// On insert every cell compares against the new value in parallel and the
// chain shifts in one step, and clear only resets the count, so a new item
// is accepted each cycle while the result register drains. The result is
// registered and shows in the cycle after the item is accepted. Insert into
// a full list is refused. A read rotates the chain one place per cycle
// while the result register can load and the head cell feeds it; in_stall
// stays high until the last entry is loaded. A read of an empty list gives
// one result. Operation code 3 is accepted and gives no result.
// Reset empties the list at once; the cell storage itself is not cleared.
// While out_stall is high the result register holds and, once it is full,
// in_stall rises and the chain freezes.
module sorted_list_insert
  import sli_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_operation,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_kind,
  output logic signed [31:0] out_entry,
  output logic               out_last
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cell_cmd_t        cmd;
  logic [CNT_W-1:0] count;
  logic             gt   [DEPTH];
  data_t            vals [DEPTH];

  sli_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_kind     (out_kind),
    .out_entry    (out_entry),
    .out_last     (out_last),
    .head_val     (vals[0]),
    .cmd          (cmd),
    .count        (count)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic  left_gt;
    data_t left_val;
    data_t right_val;

    if (i == 0) begin : g_head
      assign left_gt  = 1'b0;
      assign left_val = '0;
    end else begin : g_mid
      assign left_gt  = gt[i-1];
      assign left_val = vals[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_val = vals[0];
    end else begin : g_body
      assign right_val = vals[i+1];
    end

    sli_cell #(
      .DEPTH (DEPTH),
      .IDX   (i)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .count     (count),
      .left_gt   (left_gt),
      .left_val  (left_val),
      .right_val (right_val),
      .head_val  (vals[0]),
      .gt        (gt[i]),
      .val       (vals[i])
    );
  end

endmodule

// ===== design/sli_cell.sv =====
// One slot of the sorted chain: holds a value, compares against the broadcast
// insert value and shifts toward its neighbors. Depends on sli_pkg.
module sli_cell
  import sli_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF,
  parameter int unsigned IDX   = 0,
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  cell_cmd_t        cmd,
  input  logic [CNT_W-1:0] count,
  input  logic             left_gt,
  input  data_t            left_val,
  input  data_t            right_val,
  input  data_t            head_val,
  output logic             gt,
  output data_t            val
);

  data_t val_r;
  data_t val_nxt;
  logic  occupied;

  assign occupied = CNT_W'(IDX) < count;
  // Empty slots count as larger than anything so the insert lands at the tail
  assign gt  = !occupied || (val_r > cmd.value);
  assign val = val_r;

  always_comb begin
    val_nxt = val_r;
    unique case (cmd.op)
      CELL_INSERT: begin
        // First larger slot takes the new value, later ones take the left neighbor
        if (gt) begin
          val_nxt = left_gt ? left_val : cmd.value;
        end
      end
      CELL_ROTATE: begin
        // Rotate the occupied part: the head wraps to the last occupied slot
        val_nxt = (CNT_W'(IDX) == count - CNT_W'(1)) ? head_val : right_val;
      end
      default: val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

// ===== design/sli_ctrl.sv =====
// Control for the sorted list: handshakes, entry count, read-out sequencing
// and the result register. Depends on sli_pkg.
module sli_ctrl
  import sli_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF,
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_operation,
  input  data_t            in_value,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [2:0]       out_kind,
  output data_t            out_entry,
  output logic             out_last,
  input  data_t            head_val,
  output cell_cmd_t        cmd,
  output logic [CNT_W-1:0] count
);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] rd_idx_r, rd_idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  kind_t            out_kind_r, out_kind_nxt;
  data_t            out_entry_r, out_entry_nxt;
  logic             out_last_r, out_last_nxt;

  logic can_load;
  logic accept;
  logic full;
  logic rd_last;

  assign can_load = !out_valid_r || !out_stall;
  assign full     = count_r == CNT_W'(DEPTH);
  assign rd_last  = rd_idx_r == count_r - CNT_W'(1);
  assign in_stall = (state_r != ST_IDLE) || !can_load;
  assign accept   = in_valid && !in_stall;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_operation == OP_READ && count_r != '0) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        if (can_load && rd_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs, cell command and datapath updates
  always_comb begin
    cmd.op        = CELL_HOLD;
    cmd.value     = in_value;
    count_nxt     = count_r;
    rd_idx_nxt    = rd_idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_kind_nxt  = out_kind_r;
    out_entry_nxt = out_entry_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_operation)
            OP_INSERT: begin
              out_valid_nxt = 1'b1;
              out_entry_nxt = '0;
              out_last_nxt  = 1'b1;
              if (full) begin
                out_kind_nxt = KIND_FULL;
              end else begin
                cmd.op       = CELL_INSERT;
                count_nxt    = count_r + CNT_W'(1);
                out_kind_nxt = KIND_INSERTED;
              end
            end
            OP_READ: begin
              rd_idx_nxt = '0;
              if (count_r == '0) begin
                out_valid_nxt = 1'b1;
                out_kind_nxt  = KIND_EMPTY;
                out_entry_nxt = '0;
                out_last_nxt  = 1'b1;
              end
            end
            OP_CLEAR: begin
              count_nxt     = '0;
              out_valid_nxt = 1'b1;
              out_kind_nxt  = KIND_CLEARED;
              out_entry_nxt = '0;
              out_last_nxt  = 1'b1;
            end
            default: ; // unused code: drop the item
          endcase
        end
      end
      ST_READ: begin
        if (can_load) begin
          // Emit the head, then rotate so the next entry comes to the head
          cmd.op        = CELL_ROTATE;
          rd_idx_nxt    = rd_idx_r + CNT_W'(1);
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_ENTRY;
          out_entry_nxt = head_val;
          out_last_nxt  = rd_last;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      rd_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_idx_r    <= rd_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_kind_r  <= out_kind_nxt;
    out_entry_r <= out_entry_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_entry = out_entry_r;
  assign out_last  = out_last_r;
  assign count     = count_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count beyond depth");

  a_insert_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == CELL_INSERT |-> !full && state_r == ST_IDLE)
    else $error("insert issued to a full chain");

  a_rotate_in_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == CELL_ROTATE |-> state_r == ST_READ && rd_idx_r < count_r)
    else $error("rotate outside read-out");

  a_read_holds_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_READ |=> count_r == $past(count_r))
    else $error("count changed during read-out");

  a_read_ends_last: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_READ && state_nxt == ST_IDLE |=> out_valid_r && out_last_r)
    else $error("read-out ended without a last entry");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for sorted_list_insert: predicts every result from
// its own sorted list copy and checks each item out. Uses sli_pkg and sorted_list_insert.
module testbench;
  import sli_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH      = DEPTH_DEF;
  localparam int          IDLE_LIMIT = 2000;
  localparam logic [1:0]  OP_UNUSED  = 2'd3;

  typedef struct {
    kind_t kind;
    data_t entry;
    logic  last;
  } list_result_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         in_operation;
  logic signed [31:0] in_value;
  logic               out_valid;
  logic               out_stall;
  logic [2:0]         out_kind;
  logic signed [31:0] out_entry;
  logic               out_last;

  data_t        list_model[$];
  list_result_t expected_results[$];
  int           error_count = 0;
  bit           idling_on = 1'b0;
  int           sink_hold_req = 0;

  sorted_list_insert #(.DEPTH(DEPTH)) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_kind     (out_kind),
    .out_entry    (out_entry),
    .out_last     (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic void expect_result(kind_t kind, data_t entry, logic last);
    list_result_t r;
    r.kind  = kind;
    r.entry = entry;
    r.last  = last;
    expected_results.push_back(r);
  endfunction

  // Apply one accepted item to the list copy and queue what it must produce.
  function automatic void predict_list_op(logic [1:0] op, data_t val);
    int pos;
    case (op)
      OP_INSERT: begin
        if (list_model.size() >= DEPTH) begin
          expect_result(KIND_FULL, '0, 1'b1);
        end else begin
          // place after every entry that is smaller or equal
          pos = 0;
          while (pos < list_model.size() && list_model[pos] <= val) pos++;
          list_model.insert(pos, val);
          expect_result(KIND_INSERTED, '0, 1'b1);
        end
      end
      OP_READ: begin
        if (list_model.size() == 0) begin
          expect_result(KIND_EMPTY, '0, 1'b1);
        end else begin
          foreach (list_model[i])
            expect_result(KIND_ENTRY, list_model[i], (i == list_model.size() - 1));
        end
      end
      OP_CLEAR: begin
        list_model.delete();
        expect_result(KIND_CLEARED, '0, 1'b1);
      end
      default: ;
    endcase
  endfunction

  function automatic data_t rand_value();
    case ($urandom_range(0, 3))
      0: return data_t'($urandom_range(0, 16)) - 8;
      1: begin
        if ($urandom_range(0, 1))
          return data_t'(32'h7FFF_FFFF - $urandom_range(0, 3));
        return data_t'(32'h8000_0000 + $urandom_range(0, 3));
      end
      default: return data_t'($urandom);
    endcase
  endfunction

  // Offer one item, hold it until accepted, then predict its results.
  task automatic send_item(logic [1:0] op, data_t val);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_value     <= val;
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_list_op(op, val);
  endtask

  // Receiver: pressure hold first, then random stall bursts.
  initial begin : sink_stall
    int burst_left;
    burst_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold_req > 0) begin
        out_stall <= 1'b1;
        sink_hold_req--;
      end else if (burst_left > 0) begin
        out_stall <= 1'b1;
        burst_left--;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        burst_left = $urandom_range(1, 5) - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : result_check
    list_result_t exp_r;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d entry %0d last %0b",
                                  out_kind, out_entry, out_last));
      end else begin
        exp_r = expected_results.pop_front();
        if (out_kind !== exp_r.kind)
          report_mismatch($sformatf("kind %0d, expected %0d", out_kind, exp_r.kind));
        if (out_entry !== exp_r.entry)
          report_mismatch($sformatf("entry %0d, expected %0d", out_entry, exp_r.entry));
        if (out_last !== exp_r.last)
          report_mismatch($sformatf("last %0b, expected %0b", out_last, exp_r.last));
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid === 1'b1 && in_stall === 1'b0) ||
          (out_valid === 1'b1 && out_stall === 1'b0))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("sorted_list_insert test failed");
    $finish;
  end

  // Extremes, equal values, every operation, empty read and clear, unused code.
  task automatic test_directed_basics();
    idling_on = 1'b0;
    send_item(OP_READ, data_t'(32'hFFFF_FFFF));
    send_item(OP_CLEAR, '0);
    send_item(OP_INSERT, '0);
    send_item(OP_INSERT, data_t'(32'h7FFF_FFFF));
    send_item(OP_INSERT, data_t'(32'h8000_0000));
    send_item(OP_INSERT, -1);
    send_item(OP_INSERT, 5);
    send_item(OP_INSERT, 5);
    send_item(OP_INSERT, 5);
    send_item(OP_INSERT, 1);
    send_item(OP_INSERT, data_t'(32'h8000_0000));
    send_item(OP_UNUSED, data_t'(32'hFFFF_FFFF));
    send_item(OP_READ, '0);
    send_item(OP_CLEAR, data_t'(32'h5555_5555));
    send_item(OP_READ, data_t'(32'hAAAA_AAAA));
    send_item(OP_UNUSED, '0);
    send_item(OP_INSERT, data_t'(32'h7FFF_FFFF));
    send_item(OP_READ, '0);
    send_item(OP_CLEAR, '0);
    send_item(OP_CLEAR, '0);
  endtask

  // Fill in descending order so every insert shifts the whole list, then overflow.
  task automatic test_fill_and_refuse();
    idling_on = 1'b1;
    send_item(OP_CLEAR, '0);
    for (int i = 0; i < DEPTH; i++) send_item(OP_INSERT, data_t'(1000 - 7 * i));
    send_item(OP_INSERT, data_t'(32'h8000_0000));
    send_item(OP_INSERT, data_t'(32'h7FFF_FFFF));
    send_item(OP_READ, '0);
    send_item(OP_CLEAR, '0);
  endtask

  // Hold the receiver off while items keep coming, so the input side stalls.
  task automatic test_output_backpressure();
    idling_on = 1'b0;
    sink_hold_req = 60;
    repeat (12) send_item(OP_INSERT, rand_value());
    send_item(OP_READ, '0);
    send_item(OP_CLEAR, '0);
  endtask

  // Rounds of mostly inserts with a read at the end; some rounds keep the list.
  task automatic test_random_rounds(int n_items);
    int sent;
    int fill;
    int pick;
    sent = 0;
    while (sent < n_items) begin
      idling_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 3) != 0) begin
        send_item(OP_CLEAR, rand_value());
        sent++;
      end
      fill = ($urandom_range(0, 3) == 0) ? $urandom_range(DEPTH - 2, DEPTH + 4)
                                         : $urandom_range(1, DEPTH / 2);
      repeat (fill) begin
        pick = $urandom_range(0, 29);
        if (pick == 0) send_item(OP_READ, rand_value());
        else if (pick == 1) send_item(OP_UNUSED, rand_value());
        else if (pick == 2) send_item(OP_CLEAR, rand_value());
        else send_item(OP_INSERT, rand_value());
        if (pick != 1) sent++;
      end
      send_item(OP_READ, rand_value());
      sent++;
    end
  endtask

  // No idling on either side for the tail of the run.
  task automatic test_quiet_tail();
    idling_on = 1'b0;
    send_item(OP_CLEAR, '0);
    repeat (DEPTH + 2) send_item(OP_INSERT, rand_value());
    send_item(OP_READ, '0);
    repeat (6) send_item(OP_INSERT, rand_value());
    send_item(OP_CLEAR, '0);
    send_item(OP_INSERT, rand_value());
    send_item(OP_READ, '0);
  endtask

  initial begin : main
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_operation <= OP_INSERT;
    in_value     <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_basics();
    test_fill_and_refuse();
    test_output_backpressure();
    test_random_rounds(240);
    test_quiet_tail();

    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DEPTH + 4) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));

    if (error_count == 0) begin
      $display("sorted_list_insert test passed");
    end else begin
      $display("sorted_list_insert test failed");
    end
    $finish;
  end

endmodule
